FILE: rtl/core/rrt_pkg.sv
// shared types and constants for the request tokenizer
// no dependencies; imported by rrt_parse and resp_request_tokenizer_core
`timescale 1ns / 1ps
`default_nettype none

package rrt_pkg;

    // default sizing
    localparam int RRT_LEN_BITS   = 24;
    localparam int RRT_MAX_TOKENS = 1024;

    // characters that steer the parser
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [1:0] SKIP_BYTES = 2'd2;

    // parser phase
    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_COUNT   = 4'd1,
        PH_DOLLAR  = 4'd2,
        PH_LEN     = 4'd3,
        PH_PAYLOAD = 4'd4,
        PH_SKIP    = 4'd5,
        PH_DONE    = 4'd6,
        PH_INLINE  = 4'd7,
        PH_STOP    = 4'd8
    } rrt_phase_t;

    // summary status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FORMAT   = 2'd1,
        ST_EARLY    = 2'd2,
        ST_OVERFLOW = 2'd3
    } rrt_status_t;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // input word
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_message;
    } rrt_in_t;

    // result word
    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        logic [9:0]  token_index;
        logic        token_first;
        logic        token_done;
        logic [10:0] token_count;
        logic [1:0]  status;
        logic        last;
    } rrt_out_t;

    // which result words one input byte produces
    typedef struct packed {
        logic pay_valid;
        logic sum_valid;
    } rrt_push_t;

endpackage

`default_nettype wire

FILE: rtl/core/rrt_parse.sv
// parser state and per-byte next-state logic for the request tokenizer
// depends on rrt_pkg; produces up to two result words per accepted byte
`timescale 1ns / 1ps
`default_nettype none

module rrt_parse #(
    parameter int LEN_BITS   = rrt_pkg::RRT_LEN_BITS,
    parameter int MAX_TOKENS = rrt_pkg::RRT_MAX_TOKENS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire rrt_pkg::rrt_in_t in_word,
    output rrt_pkg::rrt_push_t    push,
    output rrt_pkg::rrt_out_t     pay_word,
    output rrt_pkg::rrt_out_t     sum_word
);
    import rrt_pkg::*;

    localparam int CNT_W  = $clog2(MAX_TOKENS + 1);
    localparam int ACC_W  = (LEN_BITS > CNT_W) ? LEN_BITS : CNT_W;
    localparam int ACC_XW = ACC_W + 4;
    localparam logic [ACC_XW-1:0] CNT_LIMIT = ACC_XW'(MAX_TOKENS);
    localparam logic [ACC_XW-1:0] LEN_LIMIT = (ACC_XW'(1) << LEN_BITS) - ACC_XW'(1);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_TOKENS);

    rrt_phase_t          phase_reg, phase_next;
    logic                inline_mode_reg, inline_mode_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                saw_digit_reg, saw_digit_next;
    logic                saw_cr_reg, saw_cr_next;
    logic [CNT_W-1:0]    elements_reg, elements_next;
    logic [LEN_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [1:0]          skip_reg, skip_next;
    logic [CNT_W-1:0]    tokens_reg, tokens_next;
    logic                in_token_reg, in_token_next;
    rrt_status_t         error_reg, error_next;

    logic [7:0]        b;
    logic              eom;
    logic              is_digit;
    logic              is_ws;
    logic [ACC_XW-1:0] acc_ext;
    logic [ACC_XW-1:0] acc_cand;
    logic [ACC_XW-1:0] num_limit;

    // number line step
    logic              num_done;
    rrt_status_t       num_err;
    logic [ACC_W-1:0]  num_acc;
    logic              num_sd;
    logic              num_sc;

    // payload word parts
    logic              pay_valid;
    logic              pay_first;
    logic              pay_done;
    logic [LEN_BITS-1:0] bl_dec;
    logic [1:0]        skip_dec;
    rrt_status_t       sum_status;

    assign b        = in_word.in_byte;
    assign eom      = in_word.end_of_message;
    assign is_digit = (b >= 8'd48) && (b <= 8'd57);
    assign is_ws    = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));

    // acc * 10 + digit by shift and add
    assign acc_ext   = ACC_XW'(acc_reg);
    assign acc_cand  = (acc_ext << 3) + (acc_ext << 1) + ACC_XW'(b[3:0]);
    assign num_limit = (phase_reg == PH_COUNT) ? CNT_LIMIT : LEN_LIMIT;

    // decimal digits terminated by cr lf
    always_comb begin
        num_done = 1'b0;
        num_err  = ST_OK;
        num_acc  = acc_reg;
        num_sd   = saw_digit_reg;
        num_sc   = saw_cr_reg;
        if (saw_cr_reg) begin
            if (b == CH_LF && saw_digit_reg) begin
                num_done = 1'b1;
            end else begin
                num_err = ST_FORMAT;
            end
        end else if (is_digit) begin
            if (acc_cand > num_limit) begin
                num_err = ST_OVERFLOW;
            end else begin
                num_acc = acc_cand[ACC_W-1:0];
                num_sd  = 1'b1;
            end
        end else if (b == CH_CR) begin
            num_sc = 1'b1;
        end else begin
            num_err = ST_FORMAT;
        end
    end

    assign bl_dec   = bytes_left_reg - LEN_BITS'(1);
    assign skip_dec = (skip_reg != 2'd0) ? skip_reg - 2'd1 : skip_reg;

    // next state for one byte
    always_comb begin
        phase_next       = phase_reg;
        inline_mode_next = inline_mode_reg;
        acc_next         = acc_reg;
        saw_digit_next   = saw_digit_reg;
        saw_cr_next      = saw_cr_reg;
        elements_next    = elements_reg;
        bytes_left_next  = bytes_left_reg;
        skip_next        = skip_reg;
        tokens_next      = tokens_reg;
        in_token_next    = in_token_reg;
        error_next       = error_reg;
        pay_valid        = 1'b0;
        pay_first        = 1'b0;
        pay_done         = 1'b0;
        sum_status       = ST_OK;

        case (phase_reg)
            PH_START, PH_INLINE: begin
                if (phase_reg == PH_START && b == CH_STAR) begin
                    phase_next     = PH_COUNT;
                    acc_next       = '0;
                    saw_digit_next = 1'b0;
                    saw_cr_next    = 1'b0;
                end else begin
                    inline_mode_next = 1'b1;
                    phase_next       = PH_INLINE;
                    if (is_ws) begin
                        if (in_token_reg) begin
                            in_token_next = 1'b0;
                            tokens_next   = tokens_reg + CNT_W'(1);
                        end
                    end else if (!in_token_reg && tokens_reg >= CNT_MAX) begin
                        error_next = ST_OVERFLOW;
                        phase_next = PH_STOP;
                    end else begin
                        pay_valid     = 1'b1;
                        pay_first     = !in_token_reg;
                        pay_done      = eom;
                        in_token_next = 1'b1;
                        if (eom) begin
                            in_token_next = 1'b0;
                            tokens_next   = tokens_reg + CNT_W'(1);
                        end
                    end
                end
            end
            PH_COUNT: begin
                acc_next       = num_acc;
                saw_digit_next = num_sd;
                saw_cr_next    = num_sc;
                if (num_err != ST_OK) begin
                    error_next = num_err;
                    phase_next = PH_STOP;
                end else if (num_done) begin
                    elements_next  = acc_reg[CNT_W-1:0];
                    acc_next       = '0;
                    saw_digit_next = 1'b0;
                    saw_cr_next    = 1'b0;
                    phase_next     = (acc_reg == '0) ? PH_DONE : PH_DOLLAR;
                end
            end
            PH_DOLLAR: begin
                if (b == CH_DOLLAR) begin
                    phase_next     = PH_LEN;
                    acc_next       = '0;
                    saw_digit_next = 1'b0;
                    saw_cr_next    = 1'b0;
                end else begin
                    error_next = ST_FORMAT;
                    phase_next = PH_STOP;
                end
            end
            PH_LEN: begin
                acc_next       = num_acc;
                saw_digit_next = num_sd;
                saw_cr_next    = num_sc;
                if (num_err != ST_OK) begin
                    error_next = num_err;
                    phase_next = PH_STOP;
                end else if (num_done) begin
                    bytes_left_next = acc_reg[LEN_BITS-1:0];
                    acc_next        = '0;
                    saw_digit_next  = 1'b0;
                    saw_cr_next     = 1'b0;
                    if (acc_reg == '0) begin
                        // empty token completes on the lf
                        tokens_next   = tokens_reg + CNT_W'(1);
                        elements_next = (elements_reg != '0) ?
                                        elements_reg - CNT_W'(1) : elements_reg;
                        in_token_next = 1'b0;
                        phase_next    = PH_SKIP;
                        skip_next     = SKIP_BYTES;
                    end else begin
                        phase_next    = PH_PAYLOAD;
                        in_token_next = 1'b0;
                    end
                end
            end
            PH_PAYLOAD: begin
                pay_valid       = 1'b1;
                pay_first       = !in_token_reg;
                pay_done        = (bl_dec == '0);
                in_token_next   = 1'b1;
                bytes_left_next = bl_dec;
                if (bl_dec == '0) begin
                    tokens_next   = tokens_reg + CNT_W'(1);
                    elements_next = (elements_reg != '0) ?
                                    elements_reg - CNT_W'(1) : elements_reg;
                    in_token_next = 1'b0;
                    phase_next    = PH_SKIP;
                    skip_next     = SKIP_BYTES;
                end
            end
            PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == 2'd0) begin
                    phase_next = (elements_reg != '0) ? PH_DOLLAR : PH_DONE;
                end
            end
            default: begin
            end
        endcase

        // end of request: summary status, then back to reset state
        if (eom) begin
            if (error_next != ST_OK) begin
                sum_status = error_next;
            end else if (inline_mode_next) begin
                sum_status = ST_OK;
            end else if (elements_next == '0 &&
                         (phase_next == PH_SKIP || phase_next == PH_DONE)) begin
                sum_status = ST_OK;
            end else begin
                sum_status = ST_EARLY;
            end
        end
    end

    // result words
    always_comb begin
        pay_word             = '0;
        pay_word.kind        = KIND_PAYLOAD;
        pay_word.out_byte    = b;
        pay_word.token_index = 10'(tokens_reg);
        pay_word.token_first = pay_first;
        pay_word.token_done  = pay_done;
        pay_word.last        = !eom;

        sum_word             = '0;
        sum_word.kind        = KIND_SUMMARY;
        sum_word.token_count = 11'(tokens_next);
        sum_word.status      = sum_status;
        sum_word.last        = 1'b1;

        push.pay_valid = accept && pay_valid;
        push.sum_valid = accept && eom;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && eom)) begin
            phase_reg       <= PH_START;
            inline_mode_reg <= 1'b0;
            acc_reg         <= '0;
            saw_digit_reg   <= 1'b0;
            saw_cr_reg      <= 1'b0;
            elements_reg    <= '0;
            bytes_left_reg  <= '0;
            skip_reg        <= 2'd0;
            tokens_reg      <= '0;
            in_token_reg    <= 1'b0;
            error_reg       <= ST_OK;
        end else if (accept) begin
            phase_reg       <= phase_next;
            inline_mode_reg <= inline_mode_next;
            acc_reg         <= acc_next;
            saw_digit_reg   <= saw_digit_next;
            saw_cr_reg      <= saw_cr_next;
            elements_reg    <= elements_next;
            bytes_left_reg  <= bytes_left_next;
            skip_reg        <= skip_next;
            tokens_reg      <= tokens_next;
            in_token_reg    <= in_token_next;
            error_reg       <= error_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/resp_request_tokenizer_core.sv
// request tokenizer top level: parser plus a four-word result queue
// result words are written into the queue when their byte is accepted and leave it in order
// throughput: one byte per cycle while s_ready is high; a byte that ends a request also yields a
// summary word, so that byte pushes two words into the queue
// s_ready drops only when fewer than two queue slots are free
// reset (aresetn low, synchronous) returns the parser to start of request and empties the queue
`timescale 1ns / 1ps
`default_nettype none

module resp_request_tokenizer_core #(
    parameter int LEN_BITS   = rrt_pkg::RRT_LEN_BITS,
    parameter int MAX_TOKENS = rrt_pkg::RRT_MAX_TOKENS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire rrt_pkg::rrt_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output rrt_pkg::rrt_out_t     m_data
);
    import rrt_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    logic       accept;
    rrt_push_t  push;
    rrt_out_t   pay_word;
    rrt_out_t   sum_word;

    rrt_out_t          q_reg [QDEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] sum_slot;
    logic              pop;

    assign accept = s_valid && s_ready;

    rrt_parse #(
        .LEN_BITS   (LEN_BITS),
        .MAX_TOKENS (MAX_TOKENS)
    ) u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_word  (s_data),
        .push     (push),
        .pay_word (pay_word),
        .sum_word (sum_word)
    );

    // queue control: room for two words keeps the input open
    assign s_ready  = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign m_valid  = (count_reg != '0);
    assign m_data   = q_reg[head_reg];
    assign pop      = m_valid && m_ready;
    assign sum_slot = tail_reg + QPTR_W'(push.pay_valid);

    always_comb begin
        head_next  = head_reg + QPTR_W'(pop);
        tail_next  = tail_reg + QPTR_W'(push.pay_valid) + QPTR_W'(push.sum_valid);
        count_next = count_reg + QCNT_W'(push.pay_valid) + QCNT_W'(push.sum_valid)
                     - QCNT_W'(pop);
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // queue storage, payload word ahead of summary word
    always_ff @(posedge aclk) begin
        if (push.pay_valid) begin
            q_reg[tail_reg] <= pay_word;
        end
        if (push.sum_valid) begin
            q_reg[sum_slot] <= sum_word;
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for resp_request_tokenizer_core: directed and random requests
// depends on rrt_pkg and the core RTL; an internal tokenizer model predicts every result word
`timescale 1ns / 1ps

module tb_top;
    import rrt_pkg::*;

    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;
    localparam longint unsigned LEN_LIMIT = (64'd1 << RRT_LEN_BITS) - 64'd1;
    localparam int RANDOM_BYTES = 750;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    rrt_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rrt_out_t m_data;

    resp_request_tokenizer_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // idle percentages for the two sides
    int send_idle_pct = 19;
    int recv_idle_pct = 80;

    rrt_out_t   predicted_words[$];
    logic [7:0] req_bytes[$];
    int bytes_sent    = 0;
    int requests_sent = 0;
    int words_checked = 0;
    int mismatches    = 0;

    // tokenizer state as predicted
    rrt_phase_t      prs_phase;
    logic            prs_inline;
    longint unsigned prs_num;
    logic            prs_digit;
    logic            prs_cr;
    int unsigned     prs_elems;
    longint unsigned prs_left;
    int unsigned     prs_skip;
    int unsigned     prs_tokens;
    logic            prs_in_tok;
    rrt_status_t     prs_err;

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // result side stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic string word_text(rrt_out_t w);
        return $sformatf({"kind=%0d byte=%02h idx=%0d first=%0d done=%0d ",
                          "count=%0d status=%0d last=%0d"},
                         w.kind, w.out_byte, w.token_index, w.token_first, w.token_done,
                         w.token_count, w.status, w.last);
    endfunction

    function void clear_number();
        prs_num   = 0;
        prs_digit = 1'b0;
        prs_cr    = 1'b0;
    endfunction

    function void parser_clear();
        prs_phase  = PH_START;
        prs_inline = 1'b0;
        clear_number();
        prs_elems  = 0;
        prs_left   = 0;
        prs_skip   = 0;
        prs_tokens = 0;
        prs_in_tok = 1'b0;
        prs_err    = ST_OK;
    endfunction

    function void halt_parse(rrt_status_t code);
        prs_err   = code;
        prs_phase = PH_STOP;
    endfunction

    function void push_word(logic knd, logic [7:0] ch, logic [9:0] idx, logic fst, logic dn,
                            logic [10:0] cnt, rrt_status_t st);
        rrt_out_t w;
        w             = '0;
        w.kind        = knd;
        w.out_byte    = ch;
        w.token_index = idx;
        w.token_first = fst;
        w.token_done  = dn;
        w.token_count = cnt;
        w.status      = st;
        w.last        = 1'b1;
        predicted_words = {predicted_words, w};
    endfunction

    // decimal number ended by cr lf; returns 1 on the lf
    function bit number_byte(logic [7:0] ch, longint unsigned limit);
        longint unsigned v;
        if (prs_cr) begin
            if (ch == CH_LF && prs_digit)
                return 1'b1;
            halt_parse(ST_FORMAT);
        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            v = prs_num * 10 + (ch - CH_ZERO);
            if (v > limit) begin
                halt_parse(ST_OVERFLOW);
            end else begin
                prs_num   = v;
                prs_digit = 1'b1;
            end
        end else if (ch == CH_CR) begin
            prs_cr = 1'b1;
        end else begin
            halt_parse(ST_FORMAT);
        end
        return 1'b0;
    endfunction

    // whitespace-split tokens
    function void inline_char(logic [7:0] ch, logic eom);
        logic ws;
        logic fst;
        ws  = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
        fst = 1'b0;
        if (ws) begin
            if (prs_in_tok) begin
                prs_in_tok = 1'b0;
                prs_tokens++;
            end
            return;
        end
        if (!prs_in_tok) begin
            if (prs_tokens >= RRT_MAX_TOKENS) begin
                halt_parse(ST_OVERFLOW);
                return;
            end
            fst        = 1'b1;
            prs_in_tok = 1'b1;
        end
        push_word(KIND_PAYLOAD, ch, 10'(prs_tokens), fst, eom, '0, ST_OK);
        if (eom) begin
            prs_in_tok = 1'b0;
            prs_tokens++;
        end
    endfunction

    function void finish_token();
        prs_tokens++;
        if (prs_elems > 0)
            prs_elems--;
        prs_in_tok = 1'b0;
        prs_phase  = PH_SKIP;
        prs_skip   = SKIP_BYTES;
    endfunction

    // expected words for one accepted byte
    function void predict_byte(logic [7:0] ch, logic eom);
        int unsigned base;
        rrt_status_t st;
        logic        fst;
        base = predicted_words.size();
        case (prs_phase)
            PH_START: begin
                if (ch == CH_STAR) begin
                    prs_phase = PH_COUNT;
                    clear_number();
                end else begin
                    prs_inline = 1'b1;
                    prs_phase  = PH_INLINE;
                    inline_char(ch, eom);
                end
            end
            PH_COUNT: begin
                if (number_byte(ch, RRT_MAX_TOKENS)) begin
                    prs_elems = 32'(prs_num);
                    clear_number();
                    prs_phase = (prs_elems != 0) ? PH_DOLLAR : PH_DONE;
                end
            end
            PH_DOLLAR: begin
                if (ch == CH_DOLLAR) begin
                    prs_phase = PH_LEN;
                    clear_number();
                end else begin
                    halt_parse(ST_FORMAT);
                end
            end
            PH_LEN: begin
                if (number_byte(ch, LEN_LIMIT)) begin
                    prs_left = prs_num;
                    clear_number();
                    if (prs_left == 0) begin
                        finish_token();
                    end else begin
                        prs_phase  = PH_PAYLOAD;
                        prs_in_tok = 1'b0;
                    end
                end
            end
            PH_PAYLOAD: begin
                fst        = !prs_in_tok;
                prs_in_tok = 1'b1;
                prs_left--;
                push_word(KIND_PAYLOAD, ch, 10'(prs_tokens), fst, prs_left == 0, '0, ST_OK);
                if (prs_left == 0)
                    finish_token();
            end
            PH_SKIP: begin
                if (prs_skip > 0)
                    prs_skip--;
                if (prs_skip == 0)
                    prs_phase = (prs_elems != 0) ? PH_DOLLAR : PH_DONE;
            end
            PH_INLINE: begin
                inline_char(ch, eom);
            end
            default: ;
        endcase

        // summary word on the final byte
        if (eom) begin
            if (prs_err != ST_OK)
                st = prs_err;
            else if (prs_inline)
                st = ST_OK;
            else if (prs_elems == 0 && (prs_phase == PH_SKIP || prs_phase == PH_DONE))
                st = ST_OK;
            else
                st = ST_EARLY;
            if (predicted_words.size() > base)
                predicted_words[predicted_words.size() - 1].last = 1'b0;
            push_word(KIND_SUMMARY, '0, '0, 1'b0, 1'b0, 11'(prs_tokens), st);
            parser_clear();
        end
    endfunction

    // result checker: a word moves at the next edge when valid and ready are high now
    always @(negedge aclk) begin : word_check
        rrt_out_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            words_checked++;
            if (predicted_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: %s", word_text(m_data));
            end else begin
                exp_w = predicted_words.pop_front();
                if (m_data.kind !== exp_w.kind || m_data.out_byte !== exp_w.out_byte ||
                    m_data.token_index !== exp_w.token_index ||
                    m_data.token_first !== exp_w.token_first ||
                    m_data.token_done !== exp_w.token_done ||
                    m_data.token_count !== exp_w.token_count ||
                    m_data.status !== exp_w.status || m_data.last !== exp_w.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", word_text(exp_w));
                        $display("  actual   %s", word_text(m_data));
                    end
                end
            end
        end
    end

    // one input word, called at a rising edge
    task automatic send_byte(input logic [7:0] ch, input logic eom);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{in_byte: ch, end_of_message: eom};
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        predict_byte(ch, eom);
        bytes_sent++;
    endtask

    task automatic send_request();
        foreach (req_bytes[i])
            send_byte(req_bytes[i], i == req_bytes.size() - 1);
        requests_sent++;
    endtask

    function void add_byte(logic [7:0] ch);
        req_bytes = {req_bytes, ch};
    endfunction

    function void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function void add_num(longint unsigned v);
        add_text($sformatf("%0d", v));
    endfunction

    task automatic send_text(input string s);
        req_bytes.delete();
        add_text(s);
        send_request();
    endtask

    // well-formed arrays, extreme payload bytes, zero count, empty token, early end
    task automatic test_array_frames();
        req_bytes.delete();
        add_text("*2\r\n$1\r\n");
        add_byte(8'h00);
        add_text("\r\n$1\r\n");
        add_byte(8'hFF);
        send_request();
        send_text("*1\r\n$0\r\n");
        send_text("*0\r\nzz");
        send_text("*2\r\n$3\r\na");
    endtask

    // signs, missing digit, lone cr, missing dollar, both overflows, largest length
    task automatic test_malformed_numbers();
        send_text("*+");
        send_text("*\r\n");
        send_text("*1\rx");
        send_text("*1\r\nx");
        send_text("*1025");
        send_text("*1\r\n$16777216");
        send_text("*1\r\n$16777215\r\nq");
    endtask

    // inline mode: single byte, token closed by whitespace, token open at the end
    task automatic test_inline_text();
        send_text("$");
        send_text(" ab\tc");
        send_text("x y ");
        req_bytes.delete();
        add_byte(8'hFF);
        send_request();
    endtask

    // mostly well-formed arrays with random content, some inline, some broken
    function void build_random_request();
        int unsigned sel;
        int unsigned n_elems;
        longint unsigned len;
        logic huge;
        req_bytes.delete();
        sel  = $urandom_range(99);
        huge = 1'b0;
        if (sel < 15) begin
            repeat ($urandom_range(1, 12)) begin
                if ($urandom_range(2) == 0)
                    add_byte(($urandom_range(5) == 0) ? CH_SPACE
                                                      : 8'(CH_TAB + $urandom_range(4)));
                else
                    add_byte(8'($urandom_range(255)));
            end
            return;
        end
        n_elems = $urandom_range(4);
        if (sel < 18)
            n_elems = RRT_MAX_TOKENS;
        else if (sel < 20)
            n_elems = RRT_MAX_TOKENS + 1 + $urandom_range(100000);
        add_byte(CH_STAR);
        if ($urandom_range(9) == 0)
            add_byte(CH_ZERO);
        add_num(n_elems);
        add_text("\r\n");
        for (int e = 0; e < n_elems && e < 4 && !huge; e++) begin
            add_byte(CH_DOLLAR);
            len = $urandom_range(6);
            if ($urandom_range(49) == 0) begin
                len  = LEN_LIMIT;
                huge = 1'b1;
            end
            add_num(len);
            add_text("\r\n");
            repeat (huge ? 2 : len)
                add_byte(8'($urandom_range(255)));
            if (!huge) begin
                if ($urandom_range(3) == 0) begin
                    add_byte(8'($urandom_range(255)));
                    add_byte(8'($urandom_range(255)));
                end else begin
                    add_text("\r\n");
                end
            end
        end
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3))
                add_byte(8'($urandom_range(255)));
        // broken variants: cut short or one byte corrupted
        sel = $urandom_range(99);
        if (sel < 10)
            req_bytes = req_bytes[0:$urandom_range(req_bytes.size() - 1)];
        else if (sel < 20)
            req_bytes[$urandom_range(req_bytes.size() - 1)] = 8'($urandom_range(255));
    endfunction

    // random requests across the three idling patterns
    task automatic test_random_requests();
        int start;
        int done_bytes;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            done_bytes = bytes_sent - start;
            if (done_bytes < RANDOM_BYTES / 3) begin
                send_idle_pct = 19;
                recv_idle_pct = 80;
            end else if (done_bytes < 2 * RANDOM_BYTES / 3) begin
                send_idle_pct = 80;
                recv_idle_pct = 19;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            build_random_request();
            send_request();
        end
    endtask

    // sequence
    initial begin
        parser_clear();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_array_frames();
        test_malformed_numbers();
        test_inline_text();
        test_random_requests();

        s_valid <= 1'b0;
        while (predicted_words.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d requests (%0d bytes) sent, %0d result words checked, %0d mismatches",
                 requests_sent, bytes_sent, words_checked, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("timeout with %0d result words outstanding", predicted_words.size());
        $display("FAILURE");
        $finish;
    end

endmodule
